/* rtl/itsp_pkg.sv */
// itsp_pkg: shared types, constants and tables of the timestamp parser
package itsp_pkg;

	localparam int unsigned FRACTION_DIGITS = 9;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0] POS_DASH1  = 5'd4;
	localparam logic [4:0] POS_DASH2  = 5'd7;
	localparam logic [4:0] POS_SEP    = 5'd10;
	localparam logic [4:0] POS_COLON1 = 5'd13;
	localparam logic [4:0] POS_COLON2 = 5'd16;
	localparam logic [4:0] POS_YEAR   = 5'd3;
	localparam logic [4:0] POS_MONTH  = 5'd6;
	localparam logic [4:0] POS_DAY    = 5'd9;
	localparam logic [4:0] POS_HOUR   = 5'd12;
	localparam logic [4:0] POS_MINUTE = 5'd15;
	localparam logic [4:0] POS_END    = 5'd19;

	localparam logic [6:0] MAX_HOUR = 7'd23;
	localparam logic [6:0] MAX_MIN  = 7'd59;
	localparam logic [6:0] MAX_SEC  = 7'd59;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED = 2'd1;
	localparam logic [1:0] STATUS_RANGE     = 2'd2;

	// x/25 = (x * RECIP25) >> RECIP_SHIFT for x below 4096
	localparam logic [15:0] RECIP25     = 16'd41944;
	localparam int unsigned RECIP_SHIFT = 20;

	localparam logic [14:0] YEAR_BIAS   = 15'd400;
	localparam logic [24:0] DAYS_OFFSET = 25'd865566;
	localparam logic [29:0] NS_PER_S    = 30'd1000000000;
	localparam logic [17:0] S_PER_DAY   = 18'd86400;

	localparam logic signed [41:0] SECS_MAX = 42'sd9223372036;
	localparam logic signed [41:0] SECS_MIN = -42'sd9223372037;
	localparam logic [29:0] FRAC_MAX = 30'd854775807;
	localparam logic [29:0] FRAC_MIN = 30'd145224192;

	typedef struct packed {
		logic take;
		logic step_div;
		logic step_chk;
		logic step_days;
		logic step_secs;
		logic step_lo;
		logic step_hi;
		logic load_out;
	} cmd_t;

	function automatic logic [29:0] frac_scale(input logic [3:0] k);
		logic [29:0] r;
		case (k)
			4'd0: r = 30'd1000000000;
			4'd1: r = 30'd100000000;
			4'd2: r = 30'd10000000;
			4'd3: r = 30'd1000000;
			4'd4: r = 30'd100000;
			4'd5: r = 30'd10000;
			4'd6: r = 30'd1000;
			4'd7: r = 30'd100;
			4'd8: r = 30'd10;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

	// days from march 1st to the first of the month
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1: r = 9'd306;
			4'd2: r = 9'd337;
			4'd3: r = 9'd0;
			4'd4: r = 9'd31;
			4'd5: r = 9'd61;
			4'd6: r = 9'd92;
			4'd7: r = 9'd122;
			4'd8: r = 9'd153;
			4'd9: r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			default: r = 9'd275;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

/* rtl/itsp_ctrl.sv */
// itsp_ctrl: sequencer for character intake and the conversion steps
module itsp_ctrl import itsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	input  logic last,
	output logic char_stall,
	output logic res_valid,
	input  logic res_stall,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_PARSE = 8'b00000001,
		S_DIV   = 8'b00000010,
		S_CHK   = 8'b00000100,
		S_DAYS  = 8'b00001000,
		S_SECS  = 8'b00010000,
		S_LO    = 8'b00100000,
		S_HI    = 8'b01000000,
		S_SUM   = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic res_valid_q;
	logic can_load;

	assign can_load   = !res_valid_q || !res_stall;
	assign char_stall = (state_q != S_PARSE);
	assign res_valid  = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_PARSE: if (char_valid && last) state_d = S_DIV;
			S_DIV:   state_d = S_CHK;
			S_CHK:   state_d = S_DAYS;
			S_DAYS:  state_d = S_SECS;
			S_SECS:  state_d = S_LO;
			S_LO:    state_d = S_HI;
			S_HI:    state_d = S_SUM;
			S_SUM:   if (can_load) state_d = S_PARSE;
			default: state_d = S_PARSE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.take      = (state_q == S_PARSE) && char_valid;
		cmd.step_div  = (state_q == S_DIV);
		cmd.step_chk  = (state_q == S_CHK);
		cmd.step_days = (state_q == S_DAYS);
		cmd.step_secs = (state_q == S_SECS);
		cmd.step_lo   = (state_q == S_LO);
		cmd.step_hi   = (state_q == S_HI);
		cmd.load_out  = (state_q == S_SUM) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_PARSE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/itsp_datapath.sv */
// itsp_datapath: field accumulators, calendar check and nanosecond arithmetic
module itsp_datapath import itsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [7:0]         char_code,
	output logic [1:0]         status,
	output logic signed [63:0] epoch_ns
);

	typedef enum logic [4:0] {
		PH_FIXED = 5'b00001,
		PH_AFTER = 5'b00010,
		PH_FRAC0 = 5'b00100,
		PH_FRAC  = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic        bad_q, bad_d;
	logic [13:0] year_q, year_d;
	logic [6:0]  month_q, month_d, day_q, day_d;
	logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
	logic [29:0] fraction_q, fraction_d;
	logic [3:0]  fcount_q, fcount_d;

	logic       is_digit;
	logic [3:0] dv;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dv       = 4'(char_code - CH_ZERO);

	// character intake
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		bad_d      = bad_q;
		year_d     = year_q;
		month_d    = month_q;
		day_d      = day_q;
		hour_d     = hour_q;
		minute_d   = minute_q;
		second_d   = second_q;
		fraction_d = fraction_q;
		fcount_d   = fcount_q;
		if (cmd.take && !bad_q) begin
			unique case (phase_q)
				PH_FIXED: begin
					if (pos_q == POS_DASH1 || pos_q == POS_DASH2) begin
						if (char_code != CH_DASH) bad_d = 1'b1;
					end else if (pos_q == POS_SEP) begin
						if (char_code != CH_T && char_code != CH_SPACE) bad_d = 1'b1;
					end else if (pos_q == POS_COLON1 || pos_q == POS_COLON2) begin
						if (char_code != CH_COLON) bad_d = 1'b1;
					end else if (!is_digit) begin
						bad_d = 1'b1;
					end else if (pos_q <= POS_YEAR) begin
						year_d = 14'(year_q * 14'd10 + 14'(dv));
					end else if (pos_q <= POS_MONTH) begin
						month_d = 7'(month_q * 7'd10 + 7'(dv));
					end else if (pos_q <= POS_DAY) begin
						day_d = 7'(day_q * 7'd10 + 7'(dv));
					end else if (pos_q <= POS_HOUR) begin
						hour_d = 7'(hour_q * 7'd10 + 7'(dv));
					end else if (pos_q <= POS_MINUTE) begin
						minute_d = 7'(minute_q * 7'd10 + 7'(dv));
					end else begin
						second_d = 7'(second_q * 7'd10 + 7'(dv));
					end
					pos_d = pos_q + 5'd1;
					if (pos_d >= POS_END) phase_d = PH_AFTER;
				end
				PH_AFTER: begin
					if (char_code == CH_DOT) phase_d = PH_FRAC0;
					else if (char_code == CH_Z) phase_d = PH_DONE;
					else bad_d = 1'b1;
				end
				PH_FRAC0, PH_FRAC: begin
					if (is_digit) begin
						if (fcount_q < 4'(FRACTION_DIGITS)) begin
							fraction_d = 30'(fraction_q * 30'd10 + 30'(dv));
							fcount_d   = fcount_q + 4'd1;
						end
						phase_d = PH_FRAC;
					end else if (char_code == CH_Z && phase_q == PH_FRAC) begin
						phase_d = PH_DONE;
					end else begin
						bad_d = 1'b1;
					end
				end
				PH_DONE: ;
				default: bad_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIXED;
			pos_q      <= '0;
			bad_q      <= 1'b0;
			year_q     <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			fraction_q <= '0;
			fcount_q   <= '0;
		end else if (cmd.load_out) begin
			phase_q    <= PH_FIXED;
			pos_q      <= '0;
			bad_q      <= 1'b0;
			year_q     <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			fraction_q <= '0;
			fcount_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			bad_q      <= bad_d;
			year_q     <= year_d;
			month_q    <= month_d;
			day_q      <= day_d;
			hour_q     <= hour_d;
			minute_q   <= minute_d;
			second_q   <= second_d;
			fraction_q <= fraction_d;
			fcount_q   <= fcount_d;
		end
	end

	// conversion
	logic [7:0]  yq100_q;
	logic [7:0]  q100_q;
	logic [1:0]  stat_q;
	logic signed [24:0] days_q;
	logic [18:0] tod_q;
	logic [29:0] frac_q;
	logic signed [41:0] secs_q;
	logic [63:0] acc_q;
	logic signed [51:0] hip_q;
	logic [1:0]  status_q;
	logic [63:0] ns_q;

	logic [27:0] yprod;
	logic [13:0] rem100;
	logic        leap, early, date_ok, time_bad, malformed;
	logic [14:0] yv;
	logic [23:0] y365;
	logic [23:0] days_pos;
	logic signed [24:0] days_d;
	logic signed [42:0] secs_prod;
	logic signed [41:0] secs_d;
	logic [59:0] frac_prod;
	logic        ovf;
	logic [50:0] lo_prod;
	logic signed [51:0] hi_prod;
	logic [63:0] sum;

	assign yprod  = 28'(year_q[13:2]) * 28'(RECIP25);
	assign rem100 = 14'(year_q - 14'(yq100_q) * 14'd100);
	assign leap   = (year_q[1:0] == 2'd0) && ((rem100 != 14'd0) || (yq100_q[1:0] == 2'd0));
	assign early  = (month_q <= 7'd2);
	assign date_ok = (month_q >= 7'd1) && (month_q <= 7'd12) && (day_q >= 7'd1)
		&& (day_q <= 7'(month_days(month_q[3:0], leap)));
	assign time_bad = (phase_q != PH_FIXED)
		&& (hour_q > MAX_HOUR || minute_q > MAX_MIN || second_q > MAX_SEC);
	assign malformed = bad_q || (phase_q == PH_FIXED && pos_q != POS_SEP)
		|| (phase_q == PH_FRAC0) || !date_ok || time_bad;

	assign yv       = 15'({1'b0, year_q} + YEAR_BIAS - 15'(early));
	assign y365     = 24'(yv) * 24'd365;
	assign days_pos = 24'(y365 + 24'(yv[14:2]) + 24'(q100_q[7:2])
		+ 24'(month_offset(month_q[3:0])) + 24'(day_q) - 24'(q100_q));
	assign days_d   = $signed({1'b0, days_pos}) - $signed(DAYS_OFFSET);
	assign frac_prod = 60'(fraction_q) * 60'(frac_scale(fcount_q));

	assign secs_prod = 43'(days_q) * $signed({25'b0, S_PER_DAY});
	assign secs_d    = 42'(secs_prod + $signed({24'b0, tod_q}));

	assign ovf = (secs_q > SECS_MAX) || (secs_q == SECS_MAX && frac_q > FRAC_MAX)
		|| (secs_q < SECS_MIN) || (secs_q == SECS_MIN && frac_q < FRAC_MIN);
	assign lo_prod = 51'(secs_q[20:0]) * 51'(NS_PER_S);
	assign hi_prod = 52'($signed(secs_q[41:21])) * $signed({22'b0, NS_PER_S});
	assign sum     = acc_q + (64'(hip_q) << 21);

	always_ff @(posedge clk) begin
		if (cmd.step_div) begin
			yq100_q <= 8'(yprod >> RECIP_SHIFT);
		end
		if (cmd.step_chk) begin
			stat_q <= malformed ? STATUS_MALFORMED : STATUS_OK;
			q100_q <= yq100_q + 8'd4 - 8'(early && rem100 == 14'd0);
		end
		if (cmd.step_days) begin
			days_q <= days_d;
			tod_q  <= 19'(hour_q) * 19'd3600 + 19'(minute_q) * 19'd60 + 19'(second_q);
			frac_q <= frac_prod[29:0];
		end
		if (cmd.step_secs) begin
			secs_q <= secs_d;
		end
		if (cmd.step_lo) begin
			if (stat_q == STATUS_OK && ovf) stat_q <= STATUS_RANGE;
			acc_q <= 64'(lo_prod) + 64'(frac_q);
		end
		if (cmd.step_hi) begin
			hip_q <= hi_prod;
		end
		if (cmd.load_out) begin
			status_q <= stat_q;
			ns_q     <= (stat_q == STATUS_OK) ? sum : 64'd0;
		end
	end

	assign status   = status_q;
	assign epoch_ns = $signed(ns_q);

endmodule

/* rtl/iso8601_timestamp_parser.sv */
// iso8601_timestamp_parser: top level of the streaming timestamp parser
//
// Input channel: char_code and last, handshaked by char_valid and char_stall.
// One character beat is taken per cycle while the parser is collecting text.
// The beat with last set closes the string; one result beat follows on the
// output channel: status and epoch_ns, handshaked by res_valid and res_stall.
// After the last beat is taken, the result passes the seven conversion steps
// of the sequencer (year split, calendar check, day count, seconds, two
// nanosecond partial products, final sum) and is then loaded into the output
// register. During those steps char_stall is high, so no new string is taken
// until the sequencer has passed its final sum.
// The result sits in an output register: a new string may be taken while it
// waits, and a stalled receiver only holds the sequencer at its final sum.
// Reset clears the field accumulators and the result valid; the first beat
// after reset starts a new string. After each result the field accumulators are cleared
// in the same way.
module iso8601_timestamp_parser import itsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               last,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         status,
	output logic signed [63:0] epoch_ns
);

	cmd_t cmd;

	itsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.last       (last),
		.char_stall (char_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	itsp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_code (char_code),
		.status    (status),
		.epoch_ns  (epoch_ns)
	);

endmodule
